// ----- design/iba_pkg.sv -----
// Package of the indexed block allocator: field widths, codes, defaults, command and status structs.
`default_nettype none

package iba_pkg;

   // Fixed field widths of the request and response beats.
   localparam int ID_W    = 7;
   localparam int CNT_F_W = 4;
   localparam int ST_W    = 2;
   localparam int BI_W    = 6;

   // Default geometry of the disk and the file table.
   localparam int DEF_NUM_BLOCKS      = 64;
   localparam int DEF_RESERVED_BLOCKS = 10;
   localparam int DEF_MAX_FILE_BLOCKS = 10;
   localparam int DEF_NUM_FILES       = 128;

   // Request kinds.
   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_DEL = 1'b1;

   // Response status codes.
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_TAKEN    = 2'd1;
   localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic reduce;
      logic table_rd;
      logic latch_code;
      logic alloc_step;
      logic list_rd;
      logic free_step;
      logic table_clr;
      logic load_err;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic slot_ok;
      logic go_alloc;
      logic go_free;
      logic alloc_last;
      logic free_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- design/iba_if.sv -----
// Handshake interfaces of the request and response channels.
`default_nettype none

interface iba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [iba_pkg::ID_W-1:0]    file_id;
   logic [iba_pkg::CNT_F_W-1:0] block_count;

   modport source (output valid, output req_type, output file_id, output block_count,
                   input ready);
   modport sink   (input valid, input req_type, input file_id, input block_count,
                   output ready);
endinterface

interface iba_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [iba_pkg::ST_W-1:0] status;
   logic                    block_valid;
   logic [iba_pkg::BI_W-1:0] block_index;
   logic                    last;

   modport source (output valid, output status, output block_valid, output block_index,
                   output last, input ready);
   modport sink   (input valid, input status, input block_valid, input block_index,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- design/iba_dpath.sv -----
// Datapath of the allocator: occupancy map, file tables, slot reduction and response register.
`default_nettype none

module iba_dpath #(
   parameter int NUM_BLOCKS      = iba_pkg::DEF_NUM_BLOCKS,
   parameter int RESERVED_BLOCKS = iba_pkg::DEF_RESERVED_BLOCKS,
   parameter int MAX_FILE_BLOCKS = iba_pkg::DEF_MAX_FILE_BLOCKS,
   parameter int NUM_FILES       = iba_pkg::DEF_NUM_FILES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire iba_pkg::cmd_type            cmd,
   output iba_pkg::sts_type                 sts,
   input  wire logic                        req_type,
   input  wire logic [iba_pkg::ID_W-1:0]    file_id,
   input  wire logic [iba_pkg::CNT_F_W-1:0] block_count,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic [iba_pkg::ST_W-1:0]         rsp_status,
   output logic                             rsp_block_valid,
   output logic [iba_pkg::BI_W-1:0]         rsp_block_index,
   output logic                             rsp_last
);

   localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int FW = $clog2(NUM_BLOCKS + 1);
   localparam int SW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
   localparam int IW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_FILE_BLOCKS + 1);
   localparam int RW = (SW > iba_pkg::ID_W) ? SW : iba_pkg::ID_W;
   localparam int TW = CW + 1;
   localparam int LIST_DEPTH = NUM_FILES * (2 ** IW);
   localparam logic [NUM_BLOCKS-1:0] RSV_MASK =
      NUM_BLOCKS'((32'd1 << RESERVED_BLOCKS) - 32'd1);
   localparam logic [FW-1:0] FREE_INIT = FW'(NUM_BLOCKS - RESERVED_BLOCKS);

   // Lowest clear bit of the occupancy map.
   function automatic logic [BW-1:0] first_free(input logic [NUM_BLOCKS-1:0] occ);
      logic [BW-1:0] pos;
      pos = '0;
      for (int k = NUM_BLOCKS - 1; k >= 0; k--) begin
         if (!occ[k]) pos = BW'(k);
      end
      return pos;
   endfunction

   logic [NUM_BLOCKS-1:0]     occ_ff, occ_in;
   logic [FW-1:0]             free_ff, free_in;
   logic [RW-1:0]             red_ff, red_in;
   logic                      type_ff;
   logic [iba_pkg::CNT_F_W-1:0] want_ff;
   logic [iba_pkg::ST_W-1:0]  code_ff, code_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [SW-1:0]             clr_ff, clr_in;
   logic                      out_valid_ff, out_valid_in;
   logic [iba_pkg::ST_W-1:0]  out_status_ff;
   logic                      out_bv_ff;
   logic [iba_pkg::BI_W-1:0]  out_bi_ff;
   logic                      out_last_ff;

   logic [TW-1:0]             tbl_mem [NUM_FILES];
   logic [TW-1:0]             tbl_q;
   logic [BW-1:0]             lst_mem [LIST_DEPTH];
   logic [BW-1:0]             lst_q;

   logic [SW-1:0]             slot;
   logic [SW+IW-1:0]          lst_addr;
   logic [BW-1:0]             pick;
   logic [CW-1:0]             want_c;
   logic [CW-1:0]             idx_next;
   logic                      tbl_valid;
   logic [CW-1:0]             tbl_cnt;
   logic                      want_ok;
   logic                      tbl_we;
   logic [SW-1:0]             tbl_waddr;
   logic [TW-1:0]             tbl_wdata;

   // Decoded views of the held request and the looked-up table entry.
   assign slot      = red_ff[SW-1:0];
   assign lst_addr  = {slot, idx_ff};
   assign pick      = first_free(occ_ff);
   assign want_c    = CW'(want_ff);
   assign idx_next  = CW'(idx_ff) + CW'(1);
   assign tbl_valid = tbl_q[CW];
   assign tbl_cnt   = tbl_q[CW-1:0];
   assign want_ok   = (want_ff != '0) && (32'(want_ff) <= MAX_FILE_BLOCKS) &&
                      (32'(want_ff) <= 32'(free_ff));

   // Status towards the controller.
   always_comb begin
      sts.clear_done = (clr_ff == SW'(NUM_FILES - 1));
      sts.slot_ok    = (32'(red_ff) < NUM_FILES);
      sts.go_alloc   = (type_ff == iba_pkg::REQ_ADD) && !tbl_valid && want_ok;
      sts.go_free    = (type_ff == iba_pkg::REQ_DEL) && tbl_valid;
      sts.alloc_last = (idx_next == want_c);
      sts.free_last  = (idx_next == tbl_cnt);
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   // Status code of a single-beat response, decided at lookup.
   always_comb begin
      if (type_ff == iba_pkg::REQ_DEL) begin
         code_in = tbl_valid ? iba_pkg::ST_OK : iba_pkg::ST_NOTFOUND;
      end else if (tbl_valid) begin
         code_in = iba_pkg::ST_TAKEN;
      end else if (want_ok) begin
         code_in = iba_pkg::ST_OK;
      end else begin
         code_in = iba_pkg::ST_NOSPACE;
      end
   end

   // Next values of the occupancy map, free count and counters.
   always_comb begin
      occ_in  = occ_ff;
      free_in = free_ff;
      red_in  = red_ff;
      idx_in  = idx_ff;
      clr_in  = clr_ff;
      if (cmd.capture) red_in = RW'(file_id);
      if (cmd.reduce && !sts.slot_ok) red_in = red_ff - RW'(NUM_FILES);
      if (cmd.latch_code) idx_in = '0;
      if (cmd.alloc_step) begin
         occ_in[pick] = 1'b1;
         free_in      = free_ff - FW'(1);
         idx_in       = idx_ff + IW'(1);
      end
      if (cmd.free_step) begin
         occ_in[lst_q] = 1'b0;
         free_in       = free_ff + FW'(1);
         idx_in        = idx_ff + IW'(1);
      end
      if (cmd.clear_step) clr_in = clr_ff + SW'(1);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= RSV_MASK;
         free_ff      <= FREE_INIT;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request fields, slot, beat counter and held code.
   always_ff @(posedge clock) begin
      red_ff <= red_in;
      idx_ff <= idx_in;
      if (cmd.capture) begin
         type_ff <= req_type;
         want_ff <= block_count;
      end
      if (cmd.latch_code) code_ff <= code_in;
   end

   // Write port of the file table: clearing pass, new file, deleted file.
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = slot;
      tbl_wdata = {1'b0, tbl_cnt};
      if (cmd.clear_step) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_ff;
         tbl_wdata = '0;
      end else if (cmd.alloc_step && sts.alloc_last) begin
         tbl_we    = 1'b1;
         tbl_wdata = {1'b1, want_c};
      end else if (cmd.table_clr) begin
         tbl_we    = 1'b1;
      end
   end

   // File table memory with registered read.
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      if (cmd.table_rd) tbl_q <= tbl_mem[slot];
   end

   // Block list memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.alloc_step) lst_mem[lst_addr] <= pick;
      if (cmd.list_rd) lst_q <= lst_mem[lst_addr];
   end

   // Response register: a block beat or a single status beat.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.alloc_step || cmd.load_err) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_step) begin
         out_status_ff <= iba_pkg::ST_OK;
         out_bv_ff     <= 1'b1;
         out_bi_ff     <= iba_pkg::BI_W'(pick);
         out_last_ff   <= sts.alloc_last;
      end else if (cmd.load_err) begin
         out_status_ff <= code_ff;
         out_bv_ff     <= 1'b0;
         out_bi_ff     <= '0;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_block_valid = out_bv_ff;
   assign rsp_block_index = out_bi_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

// ----- design/iba_ctrl.sv -----
// Controller of the allocator: sequences clearing, lookup, allocation and release.
`default_nettype none

module iba_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire iba_pkg::sts_type sts,
   output iba_pkg::cmd_type      cmd
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_REDUCE = 8'b0000_0100,
      S_LOOKUP = 8'b0000_1000,
      S_ALLOC  = 8'b0001_0000,
      S_DEL_RD = 8'b0010_0000,
      S_DEL_CL = 8'b0100_0000,
      S_RESULT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            if (sts.slot_ok) begin
               cmd.table_rd = 1'b1;
               state_in     = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.latch_code = 1'b1;
            if (sts.go_alloc) begin
               state_in = S_ALLOC;
            end else if (sts.go_free) begin
               state_in = S_DEL_RD;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_ALLOC: begin
            if (sts.out_free) begin
               cmd.alloc_step = 1'b1;
               if (sts.alloc_last) state_in = S_IDLE;
            end
         end
         S_DEL_RD: begin
            cmd.list_rd = 1'b1;
            state_in    = S_DEL_CL;
         end
         S_DEL_CL: begin
            cmd.free_step = 1'b1;
            if (sts.free_last) begin
               cmd.table_clr = 1'b1;
               state_in      = S_RESULT;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.load_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // State register; reset starts the clearing pass of the file table.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/indexed_block_allocator_unit.sv -----
// Top level of the indexed block allocator.
//
//   channel | dir | beat contents                              | per request
//   --------+-----+--------------------------------------------+-----------------------
//   req     | in  | req_type, file_id, block_count             | one beat
//   rsp     | out | status, block_valid, block_index, last     | 1 to MAX_FILE_BLOCKS
//
// An add is accepted, its slot reduced and its table entry looked up; then one block a
// cycle, unless the response stalls, comes from the priority encoder over the occupancy
// map; a refused request ends in a single status beat. A delete reads each block
// number from the block list memory and then clears it in the map. A file_id at or
// above NUM_FILES is reduced by repeated subtraction of NUM_FILES. After reset a
// clearing pass sweeps the file table and takes no request. A stalled response holds
// allocation and status beats; the next request may be taken while the last beat waits.
`default_nettype none

module indexed_block_allocator_unit #(
   parameter int NUM_BLOCKS      = iba_pkg::DEF_NUM_BLOCKS,
   parameter int RESERVED_BLOCKS = iba_pkg::DEF_RESERVED_BLOCKS,
   parameter int MAX_FILE_BLOCKS = iba_pkg::DEF_MAX_FILE_BLOCKS,
   parameter int NUM_FILES       = iba_pkg::DEF_NUM_FILES
) (
   input wire logic clock,
   input wire logic reset,
   iba_req_if.sink  req_chan,
   iba_rsp_if.source rsp_chan
);

   iba_pkg::cmd_type cmd;
   iba_pkg::sts_type sts;

   // Sequencer.
   iba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and response register.
   iba_dpath #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .RESERVED_BLOCKS (RESERVED_BLOCKS),
      .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS),
      .NUM_FILES       (NUM_FILES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_chan.req_type),
      .file_id         (req_chan.file_id),
      .block_count     (req_chan.block_count),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_block_valid (rsp_chan.block_valid),
      .rsp_block_index (rsp_chan.block_index),
      .rsp_last        (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ----- design/iba_checker.sv -----
// Port-level checks of the allocator and their bind to the top level.
`default_nettype none

module iba_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [iba_pkg::ST_W-1:0] rsp_status,
   input wire logic                     rsp_block_valid,
   input wire logic [iba_pkg::BI_W-1:0] rsp_block_index,
   input wire logic                     rsp_last
);

   logic [1:0] open_ff, open_in;

   // Requests taken whose last response beat has not yet been taken.
   always_comb begin
      open_in = open_ff;
      if (req_valid && req_ready) open_in = open_in + 2'd1;
      if (rsp_valid && rsp_ready && rsp_last) open_in = open_in - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A stalled response beat holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_status, rsp_block_valid, rsp_block_index, rsp_last}))
      else $error("response beat changed while stalled");

   // The clearing pass keeps the request side closed right after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the clearing pass");

   // Every response beat belongs to a request that was taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response beat without an open request");

   // At most one finished request waits on the response side when a new one is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> open_ff <= 2'd1)
      else $error("request taken while two are open");

endmodule

bind indexed_block_allocator_unit iba_checker u_iba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_block_valid (rsp_chan.block_valid),
   .rsp_block_index (rsp_chan.block_index),
   .rsp_last        (rsp_chan.last)
);

`default_nettype wire
